>>> rtl/erc_pkg.sv
package erc_pkg;

    localparam int CITY_W    = 6;
    localparam int CITY_SPAN = 64;
    localparam int SLOTS     = 4;
    localparam int SLOT_W    = 7;
    localparam int ENTRY_W   = SLOTS * SLOT_W;
    localparam int RAND_W    = 16;
    localparam int CNT_W     = 3;
    localparam int DIV_W     = 7;

    typedef struct packed {
        logic [CITY_W-1:0] parent_a_city;
        logic [CITY_W-1:0] parent_b_city;
        logic [RAND_W-1:0] random_word;
        logic              last_in;
    } t_in_item;

    typedef struct packed {
        logic [CITY_W-1:0] child_city;
        logic              last_out;
    } t_out_item;

    typedef enum logic [4:0] {
        S_LOAD, S_B_RI, S_B_RN, S_B_RP, S_B_CP, S_ADD_RD, S_ADD_WR,
        S_ST_RD, S_MOD_GO, S_MOD_WAIT, S_SCAN, S_VISIT_RD, S_VISIT_SNAP,
        S_DEL_RD, S_DEL_WR, S_EMIT, S_SEL_RD, S_SEL_CAP, S_CNT_RD,
        S_CNT_CAP, S_CNT_DONE, S_FIN
    } t_state;

    function automatic logic [ENTRY_W-1:0] nb_add_f(input logic [ENTRY_W-1:0] e,
                                                     input logic [CITY_W-1:0] nb);
        logic [ENTRY_W-1:0] r;
        logic dup;
        logic placed;
        r = e;
        dup = 1'b0;
        placed = 1'b0;
        for (int k = 0; k < SLOTS; k++) begin
            if (e[k*SLOT_W+CITY_W] && e[k*SLOT_W +: CITY_W] == nb) begin
                dup = 1'b1;
            end
        end
        for (int k = 0; k < SLOTS; k++) begin
            if (!dup && !placed && !e[k*SLOT_W+CITY_W]) begin
                r[k*SLOT_W +: SLOT_W] = {1'b1, nb};
                placed = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] nb_del_f(input logic [ENTRY_W-1:0] e,
                                                     input logic [CITY_W-1:0] nb);
        logic [ENTRY_W-1:0] r;
        r = e;
        for (int k = 0; k < SLOTS; k++) begin
            if (e[k*SLOT_W+CITY_W] && e[k*SLOT_W +: CITY_W] == nb) begin
                r[k*SLOT_W +: SLOT_W] = '0;
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] slot_count(input logic [ENTRY_W-1:0] e);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int k = 0; k < SLOTS; k++) begin
            c = c + CNT_W'(e[k*SLOT_W+CITY_W]);
        end
        return c;
    endfunction

endpackage

>>> rtl/erc_ram.sv
module erc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/erc_mod.sv
module erc_mod
    import erc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [RAND_W-1:0] r_q, n_q;
    logic [DIV_W:0]    r_rem, n_rem;
    logic [DIV_W-1:0]  r_d, n_d;
    logic [DIV_W:0]    trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        trial  = {r_rem[DIV_W-1:0], r_q[RAND_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'(RAND_W - 1);
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_d}) begin
                trial = trial - {1'b0, r_d};
            end
            n_rem = trial;
            n_q   = {r_q[RAND_W-2:0], 1'b0};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem[DIV_W-1:0];

endmodule

>>> rtl/edge_recombination_crossover.sv
// Edge recombination crossover over two parent tours.
// Input channel (i_in_valid/o_in_ready, i_in_item): one transaction per tour
// position, carrying both parent cities and a random word; last_in closes the
// tour. Positions are taken one per cycle while loading.
// Output channel (o_out_valid/i_out_ready, o_out_item): one transaction per
// offspring city, last_out set on the final one.
// After the last input transaction the block builds the neighbour table with
// four read-modify-write passes per position, then emits cities. Each city
// costs a run of the remainder unit, up to five neighbour-table reads for the
// neighbour counts and up to four more read-modify-writes to strike the city
// from the lists; when no neighbour is left a scan of the visited marks is
// added. The neighbour table has a single read port.
// No input is taken until the last offspring city is in the output register.
// A stalled receiver holds the output register; the block waits with the next
// city held internally. Reset empties the tour, the visited marks and the
// neighbour table; parent memories need no clearing.
module edge_recombination_crossover
    import erc_pkg::*;
#(
    parameter int MAX_CITIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int PW = $clog2(MAX_CITIES);
    localparam int LW = $clog2(MAX_CITIES + 1);

    t_state r_state, n_state;
    logic [LW-1:0] r_len, n_len, r_n, n_n, r_i, n_i, r_vis_cnt, n_vis_cnt;
    logic [2*CITY_W-1:0] r_pa, n_pa, r_pnx, n_pnx, r_ppv, n_ppv;
    logic [1:0] r_op, n_op;
    logic [2:0] r_k, n_k;
    logic [CITY_W-1:0] r_cur, n_cur, r_scan, n_scan, r_taddr, n_taddr;
    logic [ENTRY_W-1:0] r_snap, n_snap, r_list, n_list;
    logic [SLOTS-1:0][CNT_W-1:0] r_cnt, n_cnt;
    logic [SLOTS-1:0] r_cand, n_cand;
    logic r_fb, n_fb, r_first, n_first;
    logic [DIV_W-1:0] r_div, n_div, r_rem, n_rem;
    logic [CITY_SPAN-1:0] r_tvalid, n_tvalid, r_visited, n_visited;
    logic [CITY_W-1:0] r_pend, n_pend;
    logic r_pend_valid, n_pend_valid;
    logic r_ovalid, n_ovalid;
    t_out_item r_oitem, n_oitem;

    logic out_free, load_we;
    logic [PW-1:0] p_raddr;
    logic [2*CITY_W-1:0] p_rdata;
    logic [RAND_W-1:0] rnd_rdata;
    logic t_we;
    logic [CITY_W-1:0] t_raddr;
    logic [ENTRY_W-1:0] t_wdata, t_rdata, t_entry;
    logic m_start, m_busy, m_done;
    logic [DIV_W-1:0] m_rem;
    logic [LW-1:0] nx, pv, fbc;
    logic [CITY_W-1:0] own_c, nb_c, pick;
    logic [SLOT_W-1:0] slot_s, list_s;
    logic [CNT_W:0] minl;
    logic [CNT_W-1:0] ccount;
    logic [SLOTS-1:0] cand;
    logic [CNT_W-1:0] rank [SLOTS];

    assign out_free = !r_ovalid || i_out_ready;
    assign load_we  = (r_state == S_LOAD) && i_in_valid && (r_len < LW'(MAX_CITIES));
    assign t_entry  = r_tvalid[r_taddr] ? t_rdata : '0;
    assign nx  = (r_i + LW'(1) == r_n) ? '0 : r_i + LW'(1);
    assign pv  = (r_i == '0) ? r_n - LW'(1) : r_i - LW'(1);
    assign fbc = r_n - r_vis_cnt;
    assign own_c  = r_op[0] ? r_pa[CITY_W-1:0] : r_pa[2*CITY_W-1:CITY_W];
    assign slot_s = r_snap[r_k[1:0]*SLOT_W +: SLOT_W];
    assign list_s = r_list[r_k[1:0]*SLOT_W +: SLOT_W];

    always_comb begin
        unique case (r_op)
            2'd0:    nb_c = r_pnx[2*CITY_W-1:CITY_W];
            2'd1:    nb_c = r_pnx[CITY_W-1:0];
            2'd2:    nb_c = r_ppv[2*CITY_W-1:CITY_W];
            default: nb_c = r_ppv[CITY_W-1:0];
        endcase
    end

    always_comb begin
        minl   = (CNT_W+1)'(SLOTS + 1);
        ccount = '0;
        pick   = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (r_list[k*SLOT_W+CITY_W] && {1'b0, r_cnt[k]} < minl) begin
                minl = {1'b0, r_cnt[k]};
            end
        end
        for (int k = 0; k < SLOTS; k++) begin
            cand[k] = r_list[k*SLOT_W+CITY_W] && ({1'b0, r_cnt[k]} == minl);
            ccount  = ccount + CNT_W'(cand[k]);
        end
        for (int k = 0; k < SLOTS; k++) begin
            rank[k] = '0;
            for (int j = 0; j < SLOTS; j++) begin
                if (r_cand[j] &&
                    r_list[j*SLOT_W +: CITY_W] < r_list[k*SLOT_W +: CITY_W]) begin
                    rank[k] = rank[k] + CNT_W'(1);
                end
            end
            if (r_cand[k] && DIV_W'(rank[k]) == m_rem) begin
                pick = r_list[k*SLOT_W +: CITY_W];
            end
        end
    end

    always_comb begin
        n_state = r_state; n_len = r_len; n_n = r_n; n_i = r_i;
        n_vis_cnt = r_vis_cnt; n_pa = r_pa; n_pnx = r_pnx; n_ppv = r_ppv;
        n_op = r_op; n_k = r_k; n_cur = r_cur; n_scan = r_scan;
        n_taddr = r_taddr; n_snap = r_snap; n_list = r_list; n_cnt = r_cnt;
        n_cand = r_cand; n_fb = r_fb; n_first = r_first; n_div = r_div;
        n_rem = r_rem; n_tvalid = r_tvalid; n_visited = r_visited;
        n_pend = r_pend; n_pend_valid = r_pend_valid; n_oitem = r_oitem;
        n_ovalid = r_ovalid && !i_out_ready;
        o_in_ready = 1'b0;
        p_raddr = r_i[PW-1:0];
        t_raddr = r_taddr;
        t_we = 1'b0;
        t_wdata = '0;
        m_start = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (load_we) begin
                        n_len = r_len + LW'(1);
                    end
                    if (i_in_item.last_in) begin
                        n_n = load_we ? r_len + LW'(1) : r_len;
                        n_i = '0;
                        n_state = S_B_RI;
                    end
                end
            end
            S_B_RI: n_state = S_B_RN;
            S_B_RN: begin
                p_raddr = nx[PW-1:0];
                n_pa = p_rdata;
                n_state = S_B_RP;
            end
            S_B_RP: begin
                p_raddr = pv[PW-1:0];
                n_pnx = p_rdata;
                n_state = S_B_CP;
            end
            S_B_CP: begin
                n_ppv = p_rdata;
                n_op = '0;
                n_state = S_ADD_RD;
            end
            S_ADD_RD: begin
                t_raddr = own_c;
                n_taddr = own_c;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                t_we = 1'b1;
                t_wdata = nb_add_f(t_entry, nb_c);
                n_tvalid[r_taddr] = 1'b1;
                n_op = r_op + 2'd1;
                if (r_op != 2'd3) begin
                    n_state = S_ADD_RD;
                end else if (r_i + LW'(1) == r_n) begin
                    n_i = '0;
                    n_first = 1'b1;
                    n_div = DIV_W'(r_n);
                    n_state = S_ST_RD;
                end else begin
                    n_i = r_i + LW'(1);
                    n_state = S_B_RI;
                end
            end
            S_ST_RD: n_state = S_MOD_GO;
            S_MOD_GO: begin
                m_start = 1'b1;
                n_state = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (m_done) begin
                    if (r_first) begin
                        n_cur = m_rem[CITY_W-1:0];
                        n_first = 1'b0;
                        n_state = S_VISIT_RD;
                    end else if (!r_fb) begin
                        n_cur = pick;
                        n_state = S_VISIT_RD;
                    end else begin
                        n_rem = m_rem;
                        n_scan = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_scan = r_scan + CITY_W'(1);
                if (!r_visited[r_scan]) begin
                    if (r_rem == '0) begin
                        n_cur = r_scan;
                        n_state = S_VISIT_RD;
                    end else begin
                        n_rem = r_rem - DIV_W'(1);
                    end
                end
            end
            S_VISIT_RD: begin
                t_raddr = r_cur;
                n_taddr = r_cur;
                n_state = S_VISIT_SNAP;
            end
            S_VISIT_SNAP: begin
                n_snap = t_entry;
                n_visited[r_cur] = 1'b1;
                if (!r_visited[r_cur] && (CITY_W+1)'(r_cur) < (CITY_W+1)'(r_n)) begin
                    n_vis_cnt = r_vis_cnt + LW'(1);
                end
                n_k = '0;
                n_state = S_DEL_RD;
            end
            S_DEL_RD: begin
                if (r_k == 3'd4) begin
                    n_state = S_EMIT;
                end else if (slot_s[CITY_W]) begin
                    t_raddr = slot_s[CITY_W-1:0];
                    n_taddr = slot_s[CITY_W-1:0];
                    n_state = S_DEL_WR;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_DEL_WR: begin
                t_we = 1'b1;
                t_wdata = nb_del_f(t_entry, r_cur);
                n_tvalid[r_taddr] = 1'b1;
                n_k = r_k + 3'd1;
                n_state = S_DEL_RD;
            end
            S_EMIT: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_ovalid = 1'b1;
                        n_oitem = '{child_city: r_pend, last_out: 1'b0};
                    end
                    n_pend = r_cur;
                    n_pend_valid = 1'b1;
                    n_i = r_i + LW'(1);
                    n_state = (r_i + LW'(1) == r_n) ? S_FIN : S_SEL_RD;
                end
            end
            S_SEL_RD: begin
                t_raddr = r_cur;
                n_taddr = r_cur;
                n_state = S_SEL_CAP;
            end
            S_SEL_CAP: begin
                n_list = t_entry;
                n_k = '0;
                n_state = S_CNT_RD;
            end
            S_CNT_RD: begin
                if (r_k == 3'd4) begin
                    n_state = S_CNT_DONE;
                end else if (list_s[CITY_W]) begin
                    t_raddr = list_s[CITY_W-1:0];
                    n_taddr = list_s[CITY_W-1:0];
                    n_state = S_CNT_CAP;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_CNT_CAP: begin
                n_cnt[r_k[1:0]] = slot_count(t_entry);
                n_k = r_k + 3'd1;
                n_state = S_CNT_RD;
            end
            S_CNT_DONE: begin
                n_cand = cand;
                if (ccount != '0) begin
                    n_div = DIV_W'(ccount);
                    n_fb = 1'b0;
                    n_state = S_MOD_GO;
                end else if (fbc != '0) begin
                    n_div = DIV_W'(fbc);
                    n_fb = 1'b1;
                    n_state = S_MOD_GO;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oitem = '{child_city: r_pend, last_out: 1'b1};
                    n_pend_valid = 1'b0;
                    n_tvalid = '0;
                    n_visited = '0;
                    n_vis_cnt = '0;
                    n_len = '0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_len <= '0;
            r_vis_cnt <= '0;
            r_tvalid <= '0;
            r_visited <= '0;
            r_pend_valid <= 1'b0;
            r_ovalid <= 1'b0;
            r_first <= 1'b0;
            r_fb <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len <= n_len;
            r_vis_cnt <= n_vis_cnt;
            r_tvalid <= n_tvalid;
            r_visited <= n_visited;
            r_pend_valid <= n_pend_valid;
            r_ovalid <= n_ovalid;
            r_first <= n_first;
            r_fb <= n_fb;
        end
        r_n <= n_n; r_i <= n_i; r_pa <= n_pa; r_pnx <= n_pnx; r_ppv <= n_ppv;
        r_op <= n_op; r_k <= n_k; r_cur <= n_cur; r_scan <= n_scan;
        r_taddr <= n_taddr; r_snap <= n_snap; r_list <= n_list; r_cnt <= n_cnt;
        r_cand <= n_cand; r_div <= n_div; r_rem <= n_rem; r_pend <= n_pend;
        r_oitem <= n_oitem;
    end

    erc_ram #(.WIDTH(2*CITY_W), .DEPTH(MAX_CITIES)) u_parent_ram (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(r_len[PW-1:0]),
        .i_wdata({i_in_item.parent_a_city, i_in_item.parent_b_city}),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    erc_ram #(.WIDTH(RAND_W), .DEPTH(MAX_CITIES)) u_random_ram (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(r_len[PW-1:0]),
        .i_wdata(i_in_item.random_word),
        .i_raddr(r_i[PW-1:0]), .o_rdata(rnd_rdata)
    );

    erc_ram #(.WIDTH(ENTRY_W), .DEPTH(CITY_SPAN)) u_table_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(r_taddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    erc_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_dividend(rnd_rdata), .i_divisor(r_div),
        .o_busy(m_busy), .o_done(m_done), .o_rem(m_rem)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_CITIES))
        else $error("tour length beyond capacity");

    a_mod_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_start |-> !m_busy)
        else $error("remainder unit restarted while busy");

    a_vis_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> r_vis_cnt <= r_n)
        else $error("visited count exceeds tour length");

    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=>
            (r_state == S_LOAD && r_tvalid == '0 && r_visited == '0 && o_out_valid))
        else $error("tour end did not clear state");

endmodule

>>> tb/tb_edge_recombination_crossover.sv
module tb_edge_recombination_crossover;
    timeunit 1ns;
    timeprecision 1ps;

    import erc_pkg::*;

    localparam int TOUR_MAX   = 64;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 300;
    localparam int ITEM_GOAL  = 300;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    edge_recombination_crossover #(.MAX_CITIES(TOUR_MAX)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    t_row directed_rows[] = '{
        '{'{6'd0,  6'd0,  16'h0000, 1'b1}, 1'b1, '{6'd0, 1'b1}},
        '{'{6'd63, 6'd63, 16'hFFFF, 1'b1}, 1'b1, '{6'd0, 1'b1}},
        '{'{6'd0,  6'd2,  16'hFFFF, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd1,  6'd0,  16'h0000, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd2,  6'd1,  16'h1234, 1'b1}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd63, 6'd63, 16'h0005, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd63, 6'd0,  16'h0000, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd1,  6'd63, 16'hFFFF, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd2,  6'd2,  16'h0007, 1'b1}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd0,  6'd0,  16'h0002, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd0,  6'd0,  16'hAAAA, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd0,  6'd0,  16'h5555, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd0,  6'd0,  16'h8000, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd0,  6'd0,  16'h0001, 1'b1}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd0,  6'd4,  16'h0000, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd1,  6'd3,  16'h0001, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd2,  6'd1,  16'h0002, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd3,  6'd0,  16'h0003, 1'b0}, 1'b0, '{6'd0, 1'b0}},
        '{'{6'd4,  6'd2,  16'h7FFF, 1'b1}, 1'b0, '{6'd0, 1'b0}}
    };

    logic [CITY_W-1:0] first_tour[TOUR_MAX];
    logic [CITY_W-1:0] second_tour[TOUR_MAX];
    logic [RAND_W-1:0] choice_words[TOUR_MAX];
    int                positions_held;
    bit [SLOT_W-1:0]   adjacency[CITY_SPAN][SLOTS];
    bit [CITY_SPAN-1:0] visited;
    t_out_item         pending_cities[$];

    int error_count;
    int idle_pct;
    int stall_pct;
    int quiet_cycles = 0;
    int items_sent;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    function automatic void link_city(input int c, input int nb);
        int free_slot;
        free_slot = SLOTS;
        for (int k = 0; k < SLOTS; k++) begin
            if (adjacency[c][k][CITY_W]) begin
                if (adjacency[c][k][CITY_W-1:0] == nb) begin
                    return;
                end
            end else if (free_slot == SLOTS) begin
                free_slot = k;
            end
        end
        if (free_slot < SLOTS) begin
            adjacency[c][free_slot] = {1'b1, CITY_W'(nb)};
        end
    endfunction

    function automatic void unlink_city(input int c, input int nb);
        for (int k = 0; k < SLOTS; k++) begin
            if (adjacency[c][k][CITY_W] && adjacency[c][k][CITY_W-1:0] == nb) begin
                adjacency[c][k] = '0;
            end
        end
    endfunction

    function automatic int link_count(input int c);
        int total;
        total = 0;
        for (int k = 0; k < SLOTS; k++) begin
            total += adjacency[c][k][CITY_W];
        end
        return total;
    endfunction

    function automatic void mark_visited(input int v);
        bit [SLOT_W-1:0] snap[SLOTS];
        visited[v] = 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
            snap[k] = adjacency[v][k];
        end
        for (int k = 0; k < SLOTS; k++) begin
            if (snap[k][CITY_W]) begin
                unlink_city(snap[k][CITY_W-1:0], v);
            end
        end
    endfunction

    function automatic void build_offspring();
        int n;
        int cur;
        int nn;
        int cnt;
        int minl;
        int tmp;
        int nbs[SLOTS];
        int cand[CITY_SPAN];
        t_out_item res;
        n = positions_held;
        foreach (adjacency[c, k]) begin
            adjacency[c][k] = '0;
        end
        visited = '0;
        for (int i = 0; i < n; i++) begin
            link_city(first_tour[i], first_tour[(i + 1) % n]);
            link_city(second_tour[i], second_tour[(i + 1) % n]);
            link_city(first_tour[i], first_tour[(i + n - 1) % n]);
            link_city(second_tour[i], second_tour[(i + n - 1) % n]);
        end
        cur = choice_words[0] % n;
        mark_visited(cur);
        res.child_city = CITY_W'(cur);
        res.last_out = 1'b0;
        pending_cities = {pending_cities, res};
        for (int i = 1; i < n; i++) begin
            nn = 0;
            cnt = 0;
            minl = SLOTS + 1;
            for (int k = 0; k < SLOTS; k++) begin
                if (adjacency[cur][k][CITY_W]) begin
                    nbs[nn] = adjacency[cur][k][CITY_W-1:0];
                    nn++;
                end
            end
            for (int a = 1; a < nn; a++) begin
                for (int b = a; b > 0 && nbs[b-1] > nbs[b]; b--) begin
                    tmp = nbs[b];
                    nbs[b] = nbs[b-1];
                    nbs[b-1] = tmp;
                end
            end
            for (int a = 0; a < nn; a++) begin
                if (link_count(nbs[a]) < minl) begin
                    minl = link_count(nbs[a]);
                end
            end
            for (int a = 0; a < nn; a++) begin
                if (link_count(nbs[a]) == minl) begin
                    cand[cnt] = nbs[a];
                    cnt++;
                end
            end
            if (cnt == 0) begin
                for (int a = 0; a < n; a++) begin
                    if (!visited[a]) begin
                        cand[cnt] = a;
                        cnt++;
                    end
                end
            end
            if (cnt == 0) begin
                break;
            end
            cur = cand[choice_words[i] % cnt];
            mark_visited(cur);
            res.child_city = CITY_W'(cur);
            pending_cities = {pending_cities, res};
        end
        pending_cities[pending_cities.size()-1].last_out = 1'b1;
    endfunction

    function automatic void absorb_item(input t_in_item it, input bit typed,
                                        input t_out_item typed_result);
        if (positions_held < TOUR_MAX) begin
            first_tour[positions_held] = it.parent_a_city;
            second_tour[positions_held] = it.parent_b_city;
            choice_words[positions_held] = it.random_word;
            positions_held++;
        end
        if (it.last_in) begin
            if (typed) begin
                pending_cities = {pending_cities, typed_result};
            end else begin
                build_offspring();
            end
            positions_held = 0;
        end
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_result);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        absorb_item(it, typed, typed_result);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tour(input int n, input bit noisy);
        int order[TOUR_MAX];
        int j;
        int tmp;
        t_in_item it;
        for (int i = 0; i < TOUR_MAX; i++) begin
            order[i] = i;
        end
        for (int i = 0; i < n; i++) begin
            if (noisy || n > TOUR_MAX) begin
                it.parent_a_city = CITY_W'($urandom_range(0, CITY_SPAN - 1));
                it.parent_b_city = CITY_W'($urandom_range(0, CITY_SPAN - 1));
            end else begin
                if (i == 0) begin
                    for (int k = n - 1; k > 0; k--) begin
                        j = $urandom_range(0, k);
                        tmp = order[k];
                        order[k] = order[j];
                        order[j] = tmp;
                    end
                end
                it.parent_a_city = CITY_W'(order[i]);
                it.parent_b_city = CITY_W'(order[(i * 7 + $urandom_range(0, 1)) % n]);
                if ($urandom_range(0, 1)) begin
                    it.parent_b_city = CITY_W'(order[n - 1 - i]);
                end
            end
            it.random_word = RAND_W'($urandom_range(0, 65535));
            it.last_in = (i == n - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_MAX) begin
                $display("Mismatches found");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_cities.size() == 0) begin
                    report_mismatch("unexpected city", -1, o_out_item.child_city);
                end else begin
                    if (o_out_item.child_city !== pending_cities[0].child_city) begin
                        report_mismatch("child_city", pending_cities[0].child_city,
                                        o_out_item.child_city);
                    end
                    if (o_out_item.last_out !== pending_cities[0].last_out) begin
                        report_mismatch("last_out", pending_cities[0].last_out,
                                        o_out_item.last_out);
                    end
                    void'(pending_cities.pop_front());
                end
            end
        end
    end

    initial begin
        int pick;
        int big_tours;
        int phase;
        bit long_done;
        error_count = 0;
        items_sent = 0;
        positions_held = 0;
        big_tours = 0;
        long_done = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);
        end
        i_in_valid = 1'b0;

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            if ((items_sent / 70) % 4 != phase) begin
                phase = (items_sent / 70) % 4;
                i_in_valid = 1'b0;
                while (pending_cities.size() != 0) begin
                    @(negedge i_clk);
                end
                case (phase)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 71; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 71; end
                    default: begin idle_pct = 26; stall_pct = 26; end
                endcase
            end
            pick = $urandom_range(0, 19);
            if (pick == 0 && big_tours < 2) begin
                big_tours++;
                send_tour(TOUR_MAX, 1'b0);
            end else if (pick == 1 && !long_done) begin
                long_done = 1'b1;
                send_tour(TOUR_MAX + 6, 1'b1);
            end else if (pick < 6) begin
                send_tour($urandom_range(1, 12), 1'b1);
            end else begin
                send_tour($urandom_range(3, 10), 1'b0);
            end
        end
        i_in_valid = 1'b0;

        while (pending_cities.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
